[sv/gnr_pkg.sv]
// ----------------------------------------------------------------------------
// gnr_pkg: shared types and constants of the Newton-Raphson root finder
// Sequencer states, status codes, register map and register reset values.
// ----------------------------------------------------------------------------
package gnr_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_F_M1, ST_F_A1, ST_F_M2, ST_F_A2, ST_F_M3, ST_F_A3,
        ST_D_K3, ST_D_M1, ST_D_K2, ST_D_A1, ST_D_M2, ST_D_A2,
        ST_S_K6, ST_S_M, ST_S_A,
        ST_CHK,
        ST_DV1S, ST_DV1W, ST_Q1, ST_X,
        ST_DV2S, ST_DV2W, ST_Q2, ST_X1,
        ST_DIFF, ST_DONE
    } gnr_state_t;

    typedef logic [1:0] gnr_status_t;
    localparam gnr_status_t STAT_CONV  = 2'd0;
    localparam gnr_status_t STAT_LIMIT = 2'd1;
    localparam gnr_status_t STAT_ZDIV  = 2'd2;

    typedef logic [2:0] gnr_reg_idx_t;
    localparam gnr_reg_idx_t REG_CUBIC  = 3'd0;
    localparam gnr_reg_idx_t REG_SQUARE = 3'd1;
    localparam gnr_reg_idx_t REG_LINEAR = 3'd2;
    localparam gnr_reg_idx_t REG_CONST  = 3'd3;
    localparam gnr_reg_idx_t REG_MULT   = 3'd4;
    localparam gnr_reg_idx_t REG_TOL    = 3'd5;
    localparam gnr_reg_idx_t REG_MAXST  = 3'd6;

    localparam logic [31:0] RST_CUBIC  = 32'h0001_0000;
    localparam logic [31:0] RST_SQUARE = 32'hFFFF_0000;
    localparam logic [31:0] RST_LINEAR = 32'hFFFF_0000;
    localparam logic [31:0] RST_CONST  = 32'h0001_0000;
    localparam logic [3:0]  RST_MULT   = 4'd2;
    localparam logic [15:0] RST_TOL    = 16'd7;
    localparam logic [15:0] RST_MAXST  = 16'd1000;

endpackage

[sv/gnr_div.sv]
// ----------------------------------------------------------------------------
// gnr_div: bit-serial fixed-point divider
// Computes sat((|n| << FRAC_BITS) / |d|) with the quotient sign, one bit a cycle.
// ----------------------------------------------------------------------------
module gnr_div #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [WORD_BITS-1:0] num,
    input  logic signed [WORD_BITS-1:0] den,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] quot
);
    localparam int NB = WORD_BITS + FRAC_BITS;
    localparam int CB = $clog2(NB + 1);

    logic [NB-1:0]        dvd_reg, dvd_next;
    logic [NB-1:0]        q_reg, q_next;
    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [WORD_BITS-1:0] dm_reg, dm_next;
    logic                 neg_reg, neg_next;
    logic [CB-1:0]        cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic signed [WORD_BITS-1:0] quot_reg, quot_next;

    logic [WORD_BITS-1:0] nmag, dmag;
    logic [WORD_BITS:0]   remsh;
    logic                 take;
    logic [NB-1:0]        qfin, lim;
    logic [WORD_BITS-1:0] qsat;

    always_comb begin
        nmag  = num[WORD_BITS-1] ? WORD_BITS'(-num) : WORD_BITS'(num);
        dmag  = den[WORD_BITS-1] ? WORD_BITS'(-den) : WORD_BITS'(den);
        remsh = {rem_reg, dvd_reg[NB-1]};
        take  = remsh >= {1'b0, dm_reg};
        qfin  = {q_reg[NB-2:0], take};
        lim   = NB'({1'b0, {(WORD_BITS-1){1'b1}}}) + NB'(neg_reg);
        qsat  = (qfin > lim) ? WORD_BITS'(lim) : WORD_BITS'(qfin);
    end

    always_comb begin
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dm_next   = dm_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        if (start) begin
            dvd_next = {nmag, {FRAC_BITS{1'b0}}};
            q_next   = '0;
            rem_next = '0;
            dm_next  = dmag;
            neg_next = num[WORD_BITS-1] != den[WORD_BITS-1];
            cnt_next = CB'(NB - 1);
            run_next = 1'b1;
        end else if (run_reg) begin
            dvd_next = {dvd_reg[NB-2:0], 1'b0};
            q_next   = qfin;
            rem_next = take ? WORD_BITS'(remsh - {1'b0, dm_reg}) : WORD_BITS'(remsh);
            cnt_next = cnt_reg - CB'(1);
            if (cnt_reg == '0) begin
                run_next  = 1'b0;
                done_next = 1'b1;
                quot_next = neg_reg ? WORD_BITS'(-qsat) : WORD_BITS'(qsat);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        dvd_reg  <= dvd_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dm_reg   <= dm_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[sv/generalized_newton_raphson_root.sv]
// ----------------------------------------------------------------------------
// generalized_newton_raphson_root: multiple-root Newton solver for a cubic
// Iterates x = t - p*f/f' on a configured cubic until the companion estimate
// t - (p-1)*f'/f'' agrees within tolerance, the step limit hits, or a
// derivative is zero.
// ----------------------------------------------------------------------------
// Each Newton step for a start estimate runs two bit-serial divisions (Q16.16
// with the default parameters) that share one divider, and the single
// multiplier forms every product in turn; the step count depends on the data
// and max_steps. One request is in work at a time; s_tready is low from
// acceptance until the result is loaded into the output register.
module generalized_newton_raphson_root
    import gnr_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // start_estimate[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // root_estimate[31:0], step_count[47:32], status[49:48]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int W = WORD_BITS;
    localparam logic signed [64:0] WMAX_L = (65'sd1 <<< (W - 1)) - 65'sd1;
    localparam logic signed [64:0] WMIN_L = -WMAX_L - 65'sd1;
    localparam logic signed [64:0] MAX32  = 65'sd2147483647;
    localparam logic signed [64:0] MIN32  = -65'sd2147483648;

    function automatic logic signed [W-1:0] clip_w(input logic signed [64:0] v);
        logic signed [64:0] c;
        c = (v > WMAX_L) ? WMAX_L : ((v < WMIN_L) ? WMIN_L : v);
        return W'(c);
    endfunction

    function automatic logic [31:0] clip_32(input logic signed [W-1:0] v);
        logic signed [64:0] e, c;
        e = 65'(v);
        c = (e > MAX32) ? MAX32 : ((e < MIN32) ? MIN32 : e);
        return 32'(c);
    endfunction

    function automatic logic signed [W-1:0] sx32(input logic [31:0] r);
        return clip_w(65'($signed(r)));
    endfunction

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b,
                                                   input logic sub);
        logic signed [W:0] s;
        s = sub ? ((W+1)'(a) - (W+1)'(b)) : ((W+1)'(a) + (W+1)'(b));
        return clip_w(65'(s));
    endfunction

    // configuration
    logic signed [W-1:0] a3_reg, a2_reg, a1_reg, a0_reg;
    logic [3:0]          p_reg;
    logic [15:0]         tol_reg, maxst_reg;
    gnr_reg_idx_t        cidx;
    logic                cwr;

    assign cidx   = paddr[4:2];
    assign cwr    = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a3_reg    <= sx32(RST_CUBIC);
            a2_reg    <= sx32(RST_SQUARE);
            a1_reg    <= sx32(RST_LINEAR);
            a0_reg    <= sx32(RST_CONST);
            p_reg     <= RST_MULT;
            tol_reg   <= RST_TOL;
            maxst_reg <= RST_MAXST;
        end else if (cwr) begin
            unique case (cidx)
                REG_CUBIC:  a3_reg    <= sx32(pwdata);
                REG_SQUARE: a2_reg    <= sx32(pwdata);
                REG_LINEAR: a1_reg    <= sx32(pwdata);
                REG_CONST:  a0_reg    <= sx32(pwdata);
                REG_MULT:   p_reg     <= pwdata[3:0];
                REG_TOL:    tol_reg   <= pwdata[15:0];
                REG_MAXST:  maxst_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cidx)
            REG_CUBIC:  prdata = clip_32(a3_reg);
            REG_SQUARE: prdata = clip_32(a2_reg);
            REG_LINEAR: prdata = clip_32(a1_reg);
            REG_CONST:  prdata = clip_32(a0_reg);
            REG_MULT:   prdata = {28'd0, p_reg};
            REG_TOL:    prdata = {16'd0, tol_reg};
            REG_MAXST:  prdata = {16'd0, maxst_reg};
            default:    prdata = '0;
        endcase
    end

    // sequencer
    gnr_state_t state_reg, state_next;
    logic signed [W-1:0] t_reg, prod_reg, acc_reg, k2_reg, f_reg, f1_reg, f2_reg, x_reg;
    logic [15:0]         steps_reg;
    gnr_status_t         stat_reg;
    logic                ov_reg;
    logic [31:0]         ov_root_reg;
    logic [15:0]         ov_steps_reg;
    gnr_status_t         ov_stat_reg;

    logic signed [W-1:0] mul_a, mul_b;
    logic                mul_frac;
    logic signed [W-1:0] add_a, add_b;
    logic                add_sub;
    logic                div_start, div_sel2, div_done;
    logic signed [W-1:0] div_q, diff;
    logic [W-1:0]        amag, bmag, dmag;
    logic [2*W-1:0]      pmag, pshift;
    logic                pneg;
    logic [W-1:0]        psat;
    logic signed [W-1:0] mul_res, add_res;
    logic signed [4:0]   pm1;
    logic [15:0]         limit;
    logic                conv, zdiv, out_free, accept;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !ov_reg || m_tready;
    assign pm1      = $signed({1'b0, p_reg}) - 5'sd1;
    assign limit    = (maxst_reg == 16'd0) ? 16'd1 : maxst_reg;

    always_comb begin
        amag   = mul_a[W-1] ? W'(-mul_a) : W'(mul_a);
        bmag   = mul_b[W-1] ? W'(-mul_b) : W'(mul_b);
        pmag   = (2*W)'(amag) * (2*W)'(bmag);
        pshift = mul_frac ? (pmag >> FRAC_BITS) : pmag;
        pneg   = mul_a[W-1] != mul_b[W-1];
        psat   = (pshift > (2*W)'({1'b0, {(W-1){1'b1}}}) + (2*W)'(pneg))
               ? W'({1'b0, {(W-1){1'b1}}}) + W'(pneg) : W'(pshift);
        mul_res = pneg ? W'(-psat) : W'(psat);
        add_res = sat_add(add_a, add_b, add_sub);
        diff    = sat_add(x_reg, acc_reg, 1'b1);
        dmag    = diff[W-1] ? W'(-diff) : W'(diff);
        conv    = dmag < W'(tol_reg);
        zdiv    = (f1_reg == '0) || (f2_reg == '0);
    end

    gnr_div #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_sel2 ? f1_reg : f_reg),
        .den     (div_sel2 ? f2_reg : f1_reg),
        .done    (div_done),
        .quot    (div_q)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_F_M1;
            ST_F_M1:  state_next = ST_F_A1;
            ST_F_A1:  state_next = ST_F_M2;
            ST_F_M2:  state_next = ST_F_A2;
            ST_F_A2:  state_next = ST_F_M3;
            ST_F_M3:  state_next = ST_F_A3;
            ST_F_A3:  state_next = ST_D_K3;
            ST_D_K3:  state_next = ST_D_M1;
            ST_D_M1:  state_next = ST_D_K2;
            ST_D_K2:  state_next = ST_D_A1;
            ST_D_A1:  state_next = ST_D_M2;
            ST_D_M2:  state_next = ST_D_A2;
            ST_D_A2:  state_next = ST_S_K6;
            ST_S_K6:  state_next = ST_S_M;
            ST_S_M:   state_next = ST_S_A;
            ST_S_A:   state_next = ST_CHK;
            ST_CHK:   state_next = zdiv ? ST_DONE : ST_DV1S;
            ST_DV1S:  state_next = ST_DV1W;
            ST_DV1W:  if (div_done) state_next = ST_Q1;
            ST_Q1:    state_next = ST_X;
            ST_X:     state_next = ST_DV2S;
            ST_DV2S:  state_next = ST_DV2W;
            ST_DV2W:  if (div_done) state_next = ST_Q2;
            ST_Q2:    state_next = ST_X1;
            ST_X1:    state_next = ST_DIFF;
            ST_DIFF:  state_next = (conv || steps_reg >= limit) ? ST_DONE : ST_F_M1;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        mul_a     = t_reg;
        mul_b     = t_reg;
        mul_frac  = 1'b1;
        add_a     = prod_reg;
        add_b     = a1_reg;
        add_sub   = 1'b0;
        div_start = 1'b0;
        div_sel2  = 1'b0;
        unique case (state_reg)
            ST_F_M1: mul_a = a3_reg;
            ST_F_A1: add_b = a2_reg;
            ST_F_M2, ST_F_M3, ST_D_M2: mul_a = acc_reg;
            ST_F_A3: add_b = a0_reg;
            ST_D_K3: begin
                mul_a    = a3_reg;
                mul_b    = W'(3);
                mul_frac = 1'b0;
            end
            ST_D_M1, ST_S_M: mul_a = prod_reg;
            ST_D_K2: begin
                mul_a    = a2_reg;
                mul_b    = W'(2);
                mul_frac = 1'b0;
            end
            ST_D_A1, ST_S_A: add_b = k2_reg;
            ST_S_K6: begin
                mul_a    = a3_reg;
                mul_b    = W'(6);
                mul_frac = 1'b0;
            end
            ST_DV1S: div_start = 1'b1;
            ST_DV2S: begin
                div_start = 1'b1;
                div_sel2  = 1'b1;
            end
            ST_DV2W: div_sel2 = 1'b1;
            ST_Q1: begin
                mul_a    = div_q;
                mul_b    = W'({1'b0, p_reg});
                mul_frac = 1'b0;
            end
            ST_Q2: begin
                mul_a    = div_q;
                mul_b    = W'(pm1);
                mul_frac = 1'b0;
            end
            ST_X, ST_X1: begin
                add_a   = t_reg;
                add_b   = prod_reg;
                add_sub = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            steps_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) steps_reg <= '0;
            else if (state_reg == ST_X1) steps_reg <= steps_reg + 16'd1;
            if (state_reg == ST_DONE && out_free) ov_reg <= 1'b1;
            else if (m_tready) ov_reg <= 1'b0;
        end
        case (state_reg)
            ST_IDLE: t_reg <= sx32(s_tdata);
            ST_F_M1, ST_F_M2, ST_F_M3, ST_D_K3, ST_D_M1, ST_D_M2,
            ST_S_K6, ST_S_M, ST_Q1, ST_Q2: prod_reg <= mul_res;
            ST_D_K2: k2_reg <= mul_res;
            ST_F_A1, ST_F_A2, ST_D_A1, ST_X1: acc_reg <= add_res;
            ST_F_A3: f_reg  <= add_res;
            ST_D_A2: f1_reg <= add_res;
            ST_S_A:  f2_reg <= add_res;
            ST_X:    x_reg  <= add_res;
            ST_CHK: begin
                x_reg    <= t_reg;
                stat_reg <= STAT_ZDIV;
            end
            ST_DIFF: begin
                stat_reg <= conv ? STAT_CONV : STAT_LIMIT;
                t_reg    <= x_reg;
            end
            ST_DONE: begin
                if (out_free) begin
                    ov_root_reg  <= clip_32(x_reg);
                    ov_steps_reg <= steps_reg;
                    ov_stat_reg  <= stat_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {6'd0, ov_stat_reg, ov_steps_reg, ov_root_reg};

endmodule

[sv/gnr_chk.sv]
// ----------------------------------------------------------------------------
// gnr_chk: port-level checks of the root finder
// Watches the request and result channels and flags illegal sequences.
// ----------------------------------------------------------------------------
module gnr_chk
    import gnr_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[49:48] == STAT_CONV || m_tdata[49:48] == STAT_LIMIT
                      || m_tdata[49:48] == STAT_ZDIV))
        else $error("bad status code");

    a_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[49:48] != STAT_ZDIV |-> m_tdata[47:32] != 16'd0)
        else $error("finished without a step");

endmodule

bind generalized_newton_raphson_root gnr_chk u_gnr_chk (.*);

[tb/generalized_newton_raphson_root_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// generalized_newton_raphson_root_checker: result checker of the root finder
// Snoops the register port and both stream channels, predicts the root,
// step count and status for each accepted request, and compares every
// accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module generalized_newton_raphson_root_checker
    import gnr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // start_estimate[31:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,   // root_estimate[31:0], step_count[47:32], status[49:48]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          outstanding
);

    typedef struct packed {
        logic [31:0] root;
        logic [15:0] steps;
        gnr_status_t status;
    } root_result_t;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    longint      a3, a2, a1, a0;
    logic [3:0]  mult;
    logic [15:0] tol, max_steps;

    root_result_t expected_roots[$];

    function automatic longint sat32(longint v);
        if (v > WORD_MAX) return WORD_MAX;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        longint prod;
        longint m;
        prod = a * b;
        m = (prod < 0) ? -prod : prod;
        m = m >>> 16;
        return sat32((prod < 0) ? -m : m);
    endfunction

    function automatic longint fx_div(longint n, longint d);
        longint nm;
        longint dm;
        longint q;
        nm = ((n < 0) ? -n : n) <<< 16;
        dm = (d < 0) ? -d : d;
        q = nm / dm;
        return sat32(((n < 0) != (d < 0)) ? -q : q);
    endfunction

    function automatic longint fx_scale(longint v, longint k);
        return sat32(v * k);
    endfunction

    function automatic root_result_t root_search(logic [31:0] start);
        root_result_t res;
        longint t, x, x1, f, f1, f2, diff, p;
        int unsigned limit, steps;
        gnr_status_t st;
        p = longint'(mult);
        limit = (max_steps == 0) ? 1 : max_steps;
        t = longint'($signed(start));
        x = t;
        steps = 0;
        st = STAT_LIMIT;
        forever begin
            f = sat32(fx_mul(sat32(fx_mul(sat32(fx_mul(a3, t) + a2), t) + a1), t) + a0);
            f1 = sat32(fx_mul(sat32(fx_mul(fx_scale(a3, 3), t) + fx_scale(a2, 2)), t) + a1);
            f2 = sat32(fx_mul(fx_scale(a3, 6), t) + fx_scale(a2, 2));
            if (f1 == 0 || f2 == 0) begin
                x = t;
                st = STAT_ZDIV;
                break;
            end
            x = sat32(t - fx_scale(fx_div(f, f1), p));
            x1 = sat32(t - fx_scale(fx_div(f1, f2), p - 1));
            steps++;
            diff = sat32(x - x1);
            if (diff < 0) diff = -diff;
            if (diff < longint'(tol)) begin
                st = STAT_CONV;
                break;
            end
            if (steps >= limit) begin
                st = STAT_LIMIT;
                break;
            end
            t = x;
        end
        res.root = x[31:0];
        res.steps = steps[15:0];
        res.status = st;
        return res;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial begin
        errors = 0;
    end

    assign outstanding = expected_roots.size();

    always @(posedge aclk) begin
        root_result_t want;
        if (!aresetn) begin
            a3 <= longint'($signed(RST_CUBIC));
            a2 <= longint'($signed(RST_SQUARE));
            a1 <= longint'($signed(RST_LINEAR));
            a0 <= longint'($signed(RST_CONST));
            mult <= RST_MULT;
            tol <= RST_TOL;
            max_steps <= RST_MAXST;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (gnr_reg_idx_t'(paddr[4:2]))
                    REG_CUBIC:  a3 <= longint'($signed(pwdata));
                    REG_SQUARE: a2 <= longint'($signed(pwdata));
                    REG_LINEAR: a1 <= longint'($signed(pwdata));
                    REG_CONST:  a0 <= longint'($signed(pwdata));
                    REG_MULT:   mult <= pwdata[3:0];
                    REG_TOL:    tol <= pwdata[15:0];
                    REG_MAXST:  max_steps <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) expected_roots.push_back(root_search(s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_roots.size() == 0) begin
                    report("unexpected result", m_tdata[31:0], 32'd0);
                end else begin
                    want = expected_roots.pop_front();
                    if (m_tdata[31:0] !== want.root)
                        report("root_estimate", m_tdata[31:0], want.root);
                    if (m_tdata[47:32] !== want.steps)
                        report("step_count", {16'd0, m_tdata[47:32]}, {16'd0, want.steps});
                    if (m_tdata[49:48] !== want.status)
                        report("status", {30'd0, m_tdata[49:48]}, {30'd0, want.status});
                end
            end
        end
    end

endmodule

[tb/generalized_newton_raphson_root_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// generalized_newton_raphson_root_test: top of the root finder testbench
// Programs the cubic and search limits over the register port, sends
// directed and random start estimates in bursts while the result side
// stalls on its own pattern, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module generalized_newton_raphson_root_test
    import gnr_pkg::*;
();

    localparam int CYCLE_LIMIT = 8000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    int          errors, outstanding;
    int          cycles = 0;
    int          burst_left;
    int          stall_mode = 0;

    generalized_newton_raphson_root dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    generalized_newton_raphson_root_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .errors(errors), .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // hold a stall pattern for a while, then pick another
    always @(posedge aclk) begin
        if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 0);
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= ((cycles / 13) % 2 == 0);
        endcase
    end

    task automatic reg_write(gnr_reg_idx_t idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_cubic(logic [31:0] c3, logic [31:0] c2, logic [31:0] c1,
                             logic [31:0] c0);
        reg_write(REG_CUBIC, c3);
        reg_write(REG_SQUARE, c2);
        reg_write(REG_LINEAR, c1);
        reg_write(REG_CONST, c0);
    endtask

    task automatic set_search(logic [3:0] p, logic [15:0] tol, logic [15:0] steps);
        reg_write(REG_MULT, {28'd0, p});
        reg_write(REG_TOL, {16'd0, tol});
        reg_write(REG_MAXST, {16'd0, steps});
    endtask

    task automatic send_estimate(logic [31:0] value);
        s_tvalid <= 1'b1;
        s_tdata <= value;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
            burst_left = $urandom_range(1, 8);
        end
    endtask

    // drop the request and drain before touching registers
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coef;
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3, 4: return $urandom;
            default: return $urandom_range(0, 8 * 65536) - 4 * 65536;
        endcase
    endfunction

    function automatic logic [31:0] rand_estimate;
        case ($urandom_range(0, 11))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3, 4: return $urandom;
            default: return $urandom_range(0, 16 * 65536) - 8 * 65536;
        endcase
    endfunction

    function automatic logic [15:0] rand_tol;
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 64));
        endcase
    endfunction

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst_left = 3;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset cubic: double root at 1.0, derivative zero at 1.0
        send_estimate(32'h0000_0000);
        send_estimate(32'h0001_0000);
        send_estimate(32'h0000_8000);
        drain;
        set_search(4'd2, 16'd7, 16'd40);
        send_estimate(32'h7FFF_FFFF);
        send_estimate(32'h8000_0000);
        send_estimate(32'hFFFF_FFFF);
        send_estimate(32'h0000_0001);
        send_estimate(32'h0003_0000);
        drain;
        // zero tolerance runs into the step limit
        set_search(4'd1, 16'd0, 16'd3);
        send_estimate(32'h0002_0000);
        send_estimate(32'hFFFE_0000);
        drain;
        set_search(4'd8, 16'hFFFF, 16'd1);
        send_estimate(32'h0005_0000);
        send_estimate(32'h8000_0000);
        drain;
        // flat second derivative: zero divisor at the widest limit
        set_cubic(32'h0, 32'h0, 32'h0002_0000, 32'h8000_0000);
        set_search(4'd1, 16'd7, 16'hFFFF);
        send_estimate(32'h7FFF_FFFF);
        send_estimate(32'h1234_5678);
        drain;
        set_cubic(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        set_search(4'd3, 16'd100, 16'd6);
        send_estimate(32'h0001_0000);
        send_estimate(32'h8000_0000);
        drain;
        set_cubic(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_estimate(32'h7FFF_FFFF);
        send_estimate(32'hFFFF_0000);
        drain;

        for (int phase = 0; phase < 16; phase++) begin
            if (phase == 7) begin
                set_cubic(32'h0, 32'h0, rand_coef(), rand_coef());
                set_search(4'($urandom_range(1, 8)), rand_tol(), 16'hFFFF);
            end else begin
                set_cubic(rand_coef(), rand_coef(), rand_coef(), rand_coef());
                set_search(4'($urandom_range(1, 8)), rand_tol(),
                           16'($urandom_range(1, 12)));
            end
            for (int n = 0; n < 50; n++) send_estimate(rand_estimate());
            drain;
        end

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
